[hdl/ovl_pkg.sv]
package ovl_pkg;

  localparam int MAX_SITES  = 64;
  localparam int SITE_W     = 6;
  localparam int POS_W      = 10;
  localparam int VTX_W      = 12;
  localparam int VAL_W      = 13;
  localparam int OPS_W      = 11;
  localparam int SITES_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [OPS_W-1:0]   OPS_RESET   = 11'd1024;
  localparam logic [SITES_W-1:0] SITES_RESET = 7'd64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SITES = 1'b1;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_OP    = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TOUCH,
    ST_W0,
    ST_W1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear_seen;
    logic rd_en;
    logic upd;
    logic emit;
    logic sel_w1;
    logic next_touch;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_op;
    logic seen;
    logic second;
    logic out_free;
  } stat_t;

endpackage

[hdl/ovl_ctrl.sv]
module ovl_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [1:0]              in_cmd,
  output logic                    in_ready,
  input  ovl_pkg::stat_t          status,
  output ovl_pkg::ctrl_t          ctrl
);

  ovl_pkg::state_t state_r, state_nxt;
  logic accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ovl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ovl_pkg::ST_IDLE: begin
        if (accept && (in_cmd inside {ovl_pkg::CMD_OP, ovl_pkg::CMD_CLOSE})) begin
          state_nxt = ovl_pkg::ST_READ;
        end
      end
      ovl_pkg::ST_READ: begin
        state_nxt = ovl_pkg::ST_TOUCH;
      end
      ovl_pkg::ST_TOUCH: begin
        if (status.seen) begin
          state_nxt = ovl_pkg::ST_W0;
        end else if (status.is_op && !status.second) begin
          state_nxt = ovl_pkg::ST_READ;
        end else begin
          state_nxt = ovl_pkg::ST_IDLE;
        end
      end
      ovl_pkg::ST_W0: begin
        if (status.out_free) begin
          state_nxt = ovl_pkg::ST_W1;
        end
      end
      ovl_pkg::ST_W1: begin
        if (status.out_free) begin
          if (status.is_op && !status.second) begin
            state_nxt = ovl_pkg::ST_READ;
          end else begin
            state_nxt = ovl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ovl_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs; in idle the block is always ready, so a beat is just in_valid
  always_comb begin
    in_ready = 1'b0;
    ctrl     = '0;
    case (state_r)
      ovl_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        ctrl.capture    = in_valid;
        ctrl.clear_seen = in_valid && (in_cmd == ovl_pkg::CMD_BEGIN);
      end
      ovl_pkg::ST_READ: begin
        ctrl.rd_en = 1'b1;
      end
      ovl_pkg::ST_TOUCH: begin
        ctrl.upd        = status.is_op;
        ctrl.next_touch = status.is_op && !status.seen && !status.second;
      end
      ovl_pkg::ST_W0: begin
        ctrl.emit = 1'b1;
      end
      ovl_pkg::ST_W1: begin
        ctrl.emit       = 1'b1;
        ctrl.sel_w1     = 1'b1;
        ctrl.next_touch = status.out_free && status.is_op && !status.second;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

[hdl/ovl_dp.sv]
module ovl_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      in_cmd,
  input  logic [ovl_pkg::POS_W-1:0]       in_op_position,
  input  logic                            in_is_bond,
  input  logic [ovl_pkg::SITE_W-1:0]      in_site_first,
  input  logic [ovl_pkg::SITE_W-1:0]      in_site_second,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ovl_pkg::VTX_W-1:0]       out_write_addr,
  output logic [ovl_pkg::VAL_W-1:0]       out_write_value,
  output logic                            out_last_of_run,
  input  logic                            cfg_we,
  input  logic [ovl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ovl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  ovl_pkg::ctrl_t                  ctrl,
  output ovl_pkg::stat_t                  status
);

  logic [ovl_pkg::OPS_W-1:0]   ops_r;
  logic [ovl_pkg::SITES_W-1:0] sites_r;

  logic [1:0]                  cmd_r;
  logic [ovl_pkg::POS_W-1:0]   pos_r;
  logic                        bond_r;
  logic [ovl_pkg::SITE_W-1:0]  s1_r;
  logic [ovl_pkg::SITE_W-1:0]  s2_r;
  logic                        second_r;

  logic [ovl_pkg::MAX_SITES-1:0] seen_r;
  logic [ovl_pkg::VTX_W-1:0]     first_mem [ovl_pkg::MAX_SITES];
  logic [ovl_pkg::VTX_W-1:0]     last_mem  [ovl_pkg::MAX_SITES];
  logic [ovl_pkg::VTX_W-1:0]     rd_first_r;
  logic [ovl_pkg::VTX_W-1:0]     rd_last_r;

  logic                        out_valid_r;
  logic [ovl_pkg::VTX_W-1:0]   out_addr_r;
  logic [ovl_pkg::VAL_W-1:0]   out_value_r;
  logic                        out_last_r;

  logic [ovl_pkg::SITE_W-1:0]  site;
  logic                        leg;
  logic [ovl_pkg::VTX_W-1:0]   vtx;
  logic [ovl_pkg::VTX_W-1:0]   vtx_next;
  logic                        is_op;
  logic                        last_touch;
  logic                        out_free;
  logic [ovl_pkg::VAL_W-1:0]   base;
  logic [ovl_pkg::VAL_W-1:0]   bnd0;
  logic [ovl_pkg::VAL_W-1:0]   bnd1;
  logic [ovl_pkg::VTX_W-1:0]   w_addr;
  logic [ovl_pkg::VAL_W-1:0]   w_value;
  logic                        w_last;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ops_r   <= ovl_pkg::OPS_RESET;
      sites_r <= ovl_pkg::SITES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == ovl_pkg::REG_OPS) begin
        ops_r <= cfg_wdata;
      end else if (cfg_index == ovl_pkg::REG_SITES) begin
        sites_r <= cfg_wdata[ovl_pkg::SITES_W-1:0];
      end
    end
  end

  // item capture; a single-site op or close starts on the second site
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r  <= in_cmd;
      pos_r  <= in_op_position;
      bond_r <= in_is_bond;
      s1_r   <= in_site_first;
      s2_r   <= in_site_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b1;
    end else if (ctrl.capture) begin
      second_r <= !(in_is_bond && (in_cmd == ovl_pkg::CMD_OP));
    end else if (ctrl.next_touch) begin
      second_r <= 1'b1;
    end
  end

  assign is_op    = (cmd_r == ovl_pkg::CMD_OP);
  assign site     = second_r ? s2_r : s1_r;
  assign leg      = bond_r && second_r;
  // 4p + leg and 4p + leg + 2; bit 1 is free, so no adder
  assign vtx      = {pos_r, 1'b0, leg};
  assign vtx_next = {pos_r, 1'b1, leg};

  // writes of the first bond site end the run only if the second site emits nothing
  assign last_touch = second_r || !(seen_r[s2_r] || (s1_r == s2_r));

  // seen marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (ctrl.clear_seen) begin
      seen_r <= '0;
    end else if (ctrl.upd) begin
      seen_r[site] <= 1'b1;
    end
  end

  // per-site vertex memories
  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      last_mem[site] <= vtx_next;
      if (!seen_r[site]) begin
        first_mem[site] <= vtx;
      end
    end
    if (ctrl.rd_en) begin
      rd_first_r <= first_mem[site];
      rd_last_r  <= last_mem[site];
    end
  end

  // boundary indices, modulo 2^13
  assign base = {ops_r, 2'b00};
  assign bnd0 = base + ovl_pkg::VAL_W'(s2_r);
  assign bnd1 = base + ovl_pkg::VAL_W'(sites_r) + ovl_pkg::VAL_W'(s2_r);

  always_comb begin
    if (is_op) begin
      if (ctrl.sel_w1) begin
        w_addr  = rd_last_r;
        w_value = {1'b0, vtx};
        w_last  = last_touch;
      end else begin
        w_addr  = vtx;
        w_value = {1'b0, rd_last_r};
        w_last  = 1'b0;
      end
    end else begin
      if (ctrl.sel_w1) begin
        w_addr  = rd_last_r;
        w_value = bnd1;
        w_last  = 1'b1;
      end else begin
        w_addr  = rd_first_r;
        w_value = bnd0;
        w_last  = 1'b0;
      end
    end
  end

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      out_addr_r  <= w_addr;
      out_value_r <= w_value;
      out_last_r  <= w_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_addr  = out_addr_r;
  assign out_write_value = out_value_r;
  assign out_last_of_run = out_last_r;

  assign status.is_op    = is_op;
  assign status.seen     = seen_r[site];
  assign status.second   = second_r;
  assign status.out_free = out_free;

endmodule

[hdl/operator_vertex_linker.sv]
// An op or close item is captured; each site it touches, a bond's first then second, gets a
// registered read of the per-site vertex memories (READ), an update (TOUCH) and, if the site
// was seen, two write beats (W0, W1), one a cycle unless out_ready holds them off. New items
// wait until an op or close is done; a begin or unused command leaves the block ready.
// Reset (synchronous, active low): seen marks cleared, ops_in_use 1024,
//   sites_in_use 64; the vertex memories are not cleared.
module operator_vertex_linker (
  input  logic                            clk,
  input  logic                            rst_n,
  // item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_cmd,
  input  logic [ovl_pkg::POS_W-1:0]       in_op_position,
  input  logic                            in_is_bond,
  input  logic [ovl_pkg::SITE_W-1:0]      in_site_first,
  input  logic [ovl_pkg::SITE_W-1:0]      in_site_second,
  // link-table write channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ovl_pkg::VTX_W-1:0]       out_write_addr,
  output logic [ovl_pkg::VAL_W-1:0]       out_write_value,
  output logic                            out_last_of_run,
  // configuration
  input  logic                            cfg_we,
  input  logic [ovl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ovl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // controller sequences each touched site: read the site's vertices,
  // update them, then hand out two write beats if the site was seen.
  ovl_pkg::ctrl_t ctrl;
  ovl_pkg::stat_t status;

  ovl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // datapath: item registers, seen marks, vertex memories, boundary adder
  // and the output register that lets a beat wait on out_ready.
  ovl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_op_position  (in_op_position),
    .in_is_bond      (in_is_bond),
    .in_site_first   (in_site_first),
    .in_site_second  (in_site_second),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_addr  (out_write_addr),
    .out_write_value (out_write_value),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .ctrl            (ctrl),
    .status          (status)
  );

`ifndef SYNTHESIS
  // an op or close item leaves the block not ready in the cycle after it is taken
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == ovl_pkg::CMD_OP || in_cmd == ovl_pkg::CMD_CLOSE))
    |=> !in_ready)
    else $error("item accepted while a previous one was in work");

  // first beat of a pair never ends a run
  a_first_beat_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && status.out_free && !ctrl.sel_w1) |=> (out_valid && !out_last_of_run))
    else $error("first write of a pair flagged as last");

  // no beat is produced while new items are taken
  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> !in_ready)
    else $error("write beat issued in idle");
`endif

endmodule

[bench/operator_vertex_linker_tb.sv]
`timescale 1ns / 1ps

module operator_vertex_linker_tb;

  // cmd code 3 has no meaning; the block must swallow it without a write beat
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Slowest correct run: ~400 items, each up to 4 write beats held off ~15% of
  // cycles, plus the LONG_HOLD receiver hold.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 24;   // > bond op with two hits + output latency
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned PHASE_ITEMS  = 50;

  typedef struct {
    logic [1:0]                 cmd;
    logic [ovl_pkg::POS_W-1:0]  pos;
    logic                       bond;
    logic [ovl_pkg::SITE_W-1:0] s1;
    logic [ovl_pkg::SITE_W-1:0] s2;
  } op_item_t;

  typedef struct {
    logic [ovl_pkg::VTX_W-1:0] addr;
    logic [ovl_pkg::VAL_W-1:0] value;
    logic                      final_beat;
  } link_write_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     in_cmd = '0;
  logic [ovl_pkg::POS_W-1:0]      in_op_position = '0;
  logic                           in_is_bond = 1'b0;
  logic [ovl_pkg::SITE_W-1:0]     in_site_first = '0;
  logic [ovl_pkg::SITE_W-1:0]     in_site_second = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [ovl_pkg::VTX_W-1:0]      out_write_addr;
  logic [ovl_pkg::VAL_W-1:0]      out_write_value;
  logic                           out_last_of_run;
  logic                           cfg_we = 1'b0;
  logic [ovl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ovl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  operator_vertex_linker dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_op_position  (in_op_position),
    .in_is_bond      (in_is_bond),
    .in_site_first   (in_site_first),
    .in_site_second  (in_site_second),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_addr  (out_write_addr),
    .out_write_value (out_write_value),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the linker: seen marks, first/last open vertex per site, registers
  // ---------------------------------------------------------------------------
  logic [ovl_pkg::MAX_SITES-1:0] site_seen;
  logic [ovl_pkg::VTX_W-1:0]     first_vtx [ovl_pkg::MAX_SITES];
  logic [ovl_pkg::VTX_W-1:0]     last_vtx  [ovl_pkg::MAX_SITES];
  logic [ovl_pkg::OPS_W-1:0]     ops_in_use;
  logic [ovl_pkg::SITES_W-1:0]   sites_in_use;

  op_item_t    pending_items [$];   // items waiting for the driver
  link_write_t links_due [$];       // link-table writes still owed by the block

  logic        in_beat = 1'b0;      // item beat taken at the last rising edge
  logic        calm = 1'b0;         // no idling on either side while set
  logic        hold_req = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycles_run = 0;
  int unsigned mismatches = 0;
  int unsigned items_queued = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // One touched site. A revisit owes two writes joining the new leg to the
  // site's open vertex; a first visit only records it. The open vertex moves
  // to leg + 2 either way (mod 4096).
  task automatic touch_site(input logic [ovl_pkg::SITE_W-1:0] site,
                            input logic [ovl_pkg::VTX_W-1:0] vtx,
                            ref link_write_t run[$]);
    if (site_seen[site]) begin
      run.push_back('{addr: vtx, value: {1'b0, last_vtx[site]}, final_beat: 1'b0});
      run.push_back('{addr: last_vtx[site], value: {1'b0, vtx}, final_beat: 1'b0});
    end else begin
      first_vtx[site] = vtx;
      site_seen[site] = 1'b1;
    end
    last_vtx[site] = vtx + 12'd2;
  endtask

  task automatic predict_links(input op_item_t it);
    link_write_t               run [$];
    logic [ovl_pkg::VTX_W-1:0] v0;
    logic [ovl_pkg::VAL_W-1:0] base;
    v0   = {it.pos, 2'b00};
    base = {ops_in_use, 2'b00};
    case (it.cmd)
      ovl_pkg::CMD_BEGIN: site_seen = '0;
      ovl_pkg::CMD_OP: begin
        if (it.bond) begin
          // legs in order, so a bond on one site links leg 1 to leg 0 + 2
          touch_site(it.s1, v0, run);
          touch_site(it.s2, v0 + 12'd1, run);
        end else begin
          touch_site(it.s2, v0, run);
        end
      end
      ovl_pkg::CMD_CLOSE: begin
        // closing an unseen site owes nothing; the mark stays set after a close
        if (site_seen[it.s2]) begin
          run.push_back('{addr: first_vtx[it.s2],
                          value: base + ovl_pkg::VAL_W'(it.s2), final_beat: 1'b0});
          run.push_back('{addr: last_vtx[it.s2],
                          value: base + ovl_pkg::VAL_W'(sites_in_use) +
                                 ovl_pkg::VAL_W'(it.s2),
                          final_beat: 1'b0});
        end
      end
      default: ;
    endcase
    if (run.size() != 0) run[run.size() - 1].final_beat = 1'b1;
    foreach (run[i]) links_due.push_back(run[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Item driver: fed from pending_items, changes on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : item_driver
    op_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99, 0) >= 15)) begin
        nxt = pending_items.pop_front();
        in_valid       <= 1'b1;
        in_cmd         <= nxt.cmd;
        in_op_position <= nxt.pos;
        in_is_bond     <= nxt.bond;
        in_site_first  <= nxt.s1;
        in_site_second <= nxt.s2;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Write receiver: random back-pressure, plus a long hold on request
  always @(negedge clk) begin : write_receiver
    if (hold_req && hold_cycles == 0) begin
      hold_cycles <= LONG_HOLD;
      out_ready   <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99, 0) >= 15);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each item beat, checks each write beat in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    link_write_t due;
    cycles_run++;
    in_beat <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready)
      predict_links('{cmd: in_cmd, pos: in_op_position, bond: in_is_bond,
                      s1: in_site_first, s2: in_site_second});
    if (rst_n && out_valid && out_ready) begin
      if (links_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected write beat: expected none, got addr %0d value %0d last %0d",
                 $time, out_write_addr, out_write_value, out_last_of_run);
      end else begin
        due = links_due.pop_front();
        if (out_write_addr !== due.addr || out_write_value !== due.value ||
            out_last_of_run !== due.final_beat) begin
          mismatches++;
          $display("%0t: write beat mismatch: expected addr %0d value %0d last %0d, got addr %0d value %0d last %0d",
                   $time, due.addr, due.value, due.final_beat,
                   out_write_addr, out_write_value, out_last_of_run);
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycles_run >= CYCLE_LIMIT);
    $display("operator_vertex_linker regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] cmd, input logic [ovl_pkg::POS_W-1:0] pos,
                           input logic bond, input logic [ovl_pkg::SITE_W-1:0] s1,
                           input logic [ovl_pkg::SITE_W-1:0] s2);
    pending_items.push_back('{cmd: cmd, pos: pos, bond: bond, s1: s1, s2: s2});
    if (cmd != CMD_UNUSED) items_queued++;
  endtask

  // idle point: every item taken, every write seen, then let no-result items finish
  task automatic settle_links();
    while (pending_items.size() != 0 || in_valid || links_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ovl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ovl_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == ovl_pkg::REG_OPS) ops_in_use = data;
    else sites_in_use = data[ovl_pkg::SITES_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Well-formed string: begin, a run of ops at rising positions on a few sites,
  // then closes over the sites (some skipped, some repeated).
  task automatic queue_operator_string();
    int span;
    int n_ops;
    int pos;
    if ($urandom_range(3, 0) == 0) span = $urandom_range(sites_in_use, 1);
    else span = $urandom_range((sites_in_use < 8) ? sites_in_use : 8, 1);
    if (span > ovl_pkg::MAX_SITES) span = ovl_pkg::MAX_SITES;
    n_ops = $urandom_range(20, 2);
    pos   = $urandom_range(15, 0);
    push_item(ovl_pkg::CMD_BEGIN, $urandom, $urandom, $urandom, $urandom);
    repeat (n_ops) begin
      push_item(ovl_pkg::CMD_OP, pos, $urandom_range(99, 0) < 70,
                $urandom_range(span - 1, 0), $urandom_range(span - 1, 0));
      pos = (pos + $urandom_range(3, 1)) % 1024;
    end
    for (int s = 0; s < span; s++)
      if ($urandom_range(9, 0) != 0)
        push_item(ovl_pkg::CMD_CLOSE, $urandom, $urandom, $urandom, s);
    if ($urandom_range(4, 0) == 0)
      push_item(ovl_pkg::CMD_CLOSE, $urandom, $urandom, $urandom,
                $urandom_range(span - 1, 0));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int unsigned target;
    site_seen    = '0;
    ops_in_use   = ovl_pkg::OPS_RESET;
    sites_in_use = ovl_pkg::SITES_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers (1024 ops, 64 sites): field extremes and corner cases
    push_item(ovl_pkg::CMD_BEGIN, '1, 1'b1, '1, '1);
    push_item(ovl_pkg::CMD_OP, 0, 1'b0, 63, 0);          // first visit, ignored site_first
    push_item(ovl_pkg::CMD_OP, 1023, 1'b0, 0, 0);        // revisit from the top position
    push_item(ovl_pkg::CMD_OP, 5, 1'b1, 63, 0);          // bond: new site then seen site
    push_item(ovl_pkg::CMD_OP, 6, 1'b1, 63, 63);         // bond on one seen site
    push_item(ovl_pkg::CMD_OP, 7, 1'b1, 10, 10);         // bond on one new site
    push_item(CMD_UNUSED, '1, 1'b1, '1, '1);
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 63);
    push_item(ovl_pkg::CMD_CLOSE, 1023, 1'b1, 63, 63);   // repeated close
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 40);       // never seen
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 10);
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 0);
    push_item(ovl_pkg::CMD_BEGIN, 0, 1'b0, 0, 0);
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 0);        // seen mark cleared by begin
    push_item(ovl_pkg::CMD_OP, 1023, 1'b0, 0, 63);       // stale vertex memory, first visit
    push_item(ovl_pkg::CMD_OP, 1023, 1'b1, 0, 63);
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 63);
    settle_links();

    // smallest registers; positions far beyond the string length
    write_reg(ovl_pkg::REG_OPS, 1);
    write_reg(ovl_pkg::REG_SITES, 1);
    push_item(ovl_pkg::CMD_BEGIN, 0, 1'b0, 0, 0);
    push_item(ovl_pkg::CMD_OP, 900, 1'b0, 0, 5);
    push_item(ovl_pkg::CMD_OP, 901, 1'b1, 5, 0);
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 5);
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 0);
    settle_links();

    // registers past their range: boundary values wrap at 13 bits
    write_reg(ovl_pkg::REG_OPS, 2047);
    write_reg(ovl_pkg::REG_SITES, 127);
    push_item(ovl_pkg::CMD_BEGIN, 0, 1'b0, 0, 0);
    push_item(ovl_pkg::CMD_OP, 1023, 1'b1, 63, 62);
    push_item(ovl_pkg::CMD_OP, 1000, 1'b0, 0, 63);
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 63);
    push_item(ovl_pkg::CMD_CLOSE, 0, 1'b0, 0, 62);

    // random phases, a fresh register setting each time
    for (int phase = 0; phase < 5; phase++) begin
      settle_links();
      case (phase)
        0: begin
          write_reg(ovl_pkg::REG_OPS, ovl_pkg::OPS_RESET);
          write_reg(ovl_pkg::REG_SITES, ovl_pkg::CFG_DATA_W'(ovl_pkg::SITES_RESET));
          calm = 1'b1;                          // a long stretch with no idling
        end
        2: begin
          write_reg(ovl_pkg::REG_OPS, 1);
          write_reg(ovl_pkg::REG_SITES, ovl_pkg::CFG_DATA_W'(ovl_pkg::SITES_RESET));
        end
        4: begin
          write_reg(ovl_pkg::REG_OPS, ovl_pkg::OPS_RESET);
          write_reg(ovl_pkg::REG_SITES, 1);
        end
        default: begin
          write_reg(ovl_pkg::REG_OPS, $urandom_range(1024, 1));
          write_reg(ovl_pkg::REG_SITES, $urandom_range(64, 1));
        end
      endcase
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) begin
        if ($urandom_range(9, 0) < 8) queue_operator_string();
        else repeat ($urandom_range(3, 1))
          push_item($urandom_range(3, 0), $urandom_range(1023, 0), $urandom,
                    $urandom_range(63, 0), $urandom_range(63, 0));
      end
      if (phase == 0) begin
        settle_links();
        calm = 1'b0;
        // receiver holds off while a dense burst of bonds piles up behind it
        hold_req = 1'b1;
        do @(posedge clk); while (hold_cycles == 0);
        hold_req = 1'b0;
        push_item(ovl_pkg::CMD_BEGIN, 0, 1'b0, 0, 0);
        repeat (30)
          push_item(ovl_pkg::CMD_OP, $urandom_range(1023, 0), 1'b1,
                    $urandom_range(2, 0), $urandom_range(2, 0));
      end
    end

    settle_links();
    if (mismatches == 0)
      $display("operator_vertex_linker regression: pass");
    else
      $display("operator_vertex_linker regression: fail");
    $finish;
  end

endmodule
